FILE: rtl/teq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// teq_pkg
// Shared types and constants for the timed event queue.
// ----------------------------------------------------------------------------
package teq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int TIME_BITS_DEF   = 48;
  localparam int MAX_RESULTS     = 16;
  localparam int RES_W           = $clog2(MAX_RESULTS + 1);
  localparam int TAG_W           = 16;
  localparam int DELAY_W         = 32;
  localparam int DUE_W           = 48;

  localparam logic OP_POST = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [1:0] KIND_ACCEPT  = 2'd0;
  localparam logic [1:0] KIND_DROP    = 2'd1;
  localparam logic [1:0] KIND_DELIVER = 2'd2;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic ins;
    logic pop;
  } teq_cell_ctl_t;

endpackage

FILE: rtl/teq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// teq_cell
// One slot of the sorted chain: holds a due time and a tag, shifts towards
// the tail on an insert at or ahead of it and towards the head on a pop.
// ----------------------------------------------------------------------------
module teq_cell
  import teq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int TIME_BITS   = TIME_BITS_DEF,
  parameter int CELL_IDX    = 0
) (
  input  logic                               clk,
  input  logic                               rst,
  input  teq_cell_ctl_t                      ctl,
  input  logic [$clog2(QUEUE_DEPTH + 1)-1:0] count,
  input  logic [TIME_BITS-1:0]               new_due,
  input  logic [TAG_W-1:0]                   new_tag,
  input  logic [TIME_BITS-1:0]               prev_due,
  input  logic [TAG_W-1:0]                   prev_tag,
  input  logic                               prev_keep,
  input  logic [TIME_BITS-1:0]               next_due,
  input  logic [TAG_W-1:0]                   next_tag,
  output logic [TIME_BITS-1:0]               due,
  output logic [TAG_W-1:0]                   tag,
  output logic                               keep
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic occ;

  assign occ  = count > CNT_W'(CELL_IDX);
  // entries due at or before the new one stay put
  assign keep = occ && (due <= new_due);

  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (!keep) begin
        if (prev_keep) begin
          due <= new_due;
          tag <= new_tag;
        end else begin
          due <= prev_due;
          tag <= prev_tag;
        end
      end
    end else if (ctl.pop) begin
      due <= next_due;
      tag <= next_tag;
    end
  end

  a_sorted: assert property (@(posedge clk) disable iff (rst)
    (count > CNT_W'(CELL_IDX + 1)) |-> (due <= next_due))
    else $error("teq_cell: chain out of order");

endmodule

FILE: rtl/timed_event_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_event_queue
// Keeps message tags sorted by due time in a shifting chain of cells. A post
// beat (op 0) forms the due time (now plus the delay if positive, else now,
// saturating) in its accept cycle, then does the sorted insert into the chain
// and gives the single result in the post state once the output register can
// take it; entries with equal due times leave in order of posting, and a post
// to a full queue is reported as dropped. A tick beat (op 1) advances the time
// counter in its accept cycle and then pops one due entry from the head of the
// chain per cycle while the output register can take it, at most 16 per tick;
// the last result of a beat carries last, and a tick with nothing due gives no
// result. Results wait in an output register, so a stalled output holds up the
// block only once the next result is ready. The block takes one input beat at
// a time.
// ----------------------------------------------------------------------------
module timed_event_queue
  import teq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int TIME_BITS   = TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 op,
  input  logic signed [31:0]   delay_us,
  input  logic [TAG_W-1:0]     msg_tag,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           kind,
  output logic [TAG_W-1:0]     tag_out,
  output logic [DUE_W-1:0]     due_time,
  output logic                 last
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W = ((TIME_BITS > DELAY_W) ? TIME_BITS : DELAY_W) + 1;
  localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_POST  = 3'b010,
    S_DRAIN = 3'b100
  } state_t;

  state_t               state;
  logic [CNT_W-1:0]     count;
  logic [TIME_BITS-1:0] now_time;
  logic [RES_W-1:0]     n_cnt;
  logic [TIME_BITS-1:0] post_due;
  logic [TAG_W-1:0]     post_tag;

  logic                 in_accept;
  logic                 out_load;
  logic                 full;
  logic                 head_ok;
  logic                 more_ok;
  logic                 post_fire;
  logic                 drain_fire;
  logic                 delay_pos;
  logic [SUM_W-1:0]     due_sum;
  logic [TIME_BITS-1:0] due_calc;
  teq_cell_ctl_t        ctl;

  logic [TIME_BITS-1:0] cell_due  [QUEUE_DEPTH];
  logic [TAG_W-1:0]     cell_tag  [QUEUE_DEPTH];
  logic                 cell_keep [QUEUE_DEPTH];
  logic [TIME_BITS-1:0] prev_due  [QUEUE_DEPTH];
  logic [TAG_W-1:0]     prev_tag  [QUEUE_DEPTH];
  logic                 prev_keep [QUEUE_DEPTH];
  logic [TIME_BITS-1:0] next_due  [QUEUE_DEPTH];
  logic [TAG_W-1:0]     next_tag  [QUEUE_DEPTH];

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_load  = !out_valid || !out_stall;

  // due time for a post: positive delays only, saturating
  always_comb begin
    delay_pos = !delay_us[31] && (delay_us != '0);
    due_sum   = SUM_W'(now_time) + SUM_W'(delay_us[30:0]);
    if (!delay_pos) begin
      due_calc = now_time;
    end else if (due_sum > SUM_W'(TIME_MAX)) begin
      due_calc = TIME_MAX;
    end else begin
      due_calc = due_sum[TIME_BITS-1:0];
    end
  end

  always_comb begin
    full       = (count == CNT_W'(QUEUE_DEPTH));
    head_ok    = (count != '0) && (cell_due[0] <= now_time);
    more_ok    = (count > CNT_W'(1)) && (cell_due[1] <= now_time) &&
                 (n_cnt != RES_W'(MAX_RESULTS - 1));
    post_fire  = (state == S_POST) && out_load;
    drain_fire = (state == S_DRAIN) && head_ok && out_load;
    ctl.ins    = post_fire && !full;
    ctl.pop    = drain_fire;
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign prev_due[i]  = post_due;
      assign prev_tag[i]  = post_tag;
      assign prev_keep[i] = 1'b0;
    end else begin : g_body
      assign prev_due[i]  = cell_due[i-1];
      assign prev_tag[i]  = cell_tag[i-1];
      assign prev_keep[i] = cell_keep[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign next_due[i] = cell_due[i];
      assign next_tag[i] = cell_tag[i];
    end else begin : g_link
      assign next_due[i] = cell_due[i+1];
      assign next_tag[i] = cell_tag[i+1];
    end

    teq_cell #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .TIME_BITS   (TIME_BITS),
      .CELL_IDX    (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .count     (count),
      .new_due   (post_due),
      .new_tag   (post_tag),
      .prev_due  (prev_due[i]),
      .prev_tag  (prev_tag[i]),
      .prev_keep (prev_keep[i]),
      .next_due  (next_due[i]),
      .next_tag  (next_tag[i]),
      .due       (cell_due[i]),
      .tag       (cell_tag[i]),
      .keep      (cell_keep[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      now_time <= '0;
      n_cnt    <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_accept) begin
            if (op == OP_TICK) begin
              if (now_time != TIME_MAX) begin
                now_time <= now_time + 1'b1;
              end
              n_cnt <= '0;
              state <= S_DRAIN;
            end else begin
              state <= S_POST;
            end
          end
        end
        S_POST: begin
          if (out_load) begin
            if (!full) begin
              count <= count + 1'b1;
            end
            state <= S_IDLE;
          end
        end
        S_DRAIN: begin
          if (!head_ok) begin
            state <= S_IDLE;
          end else if (out_load) begin
            count <= count - 1'b1;
            n_cnt <= n_cnt + 1'b1;
            if (!more_ok) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && (op == OP_POST)) begin
      post_due <= due_calc;
      post_tag <= msg_tag;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (post_fire || drain_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (post_fire) begin
      kind     <= full ? KIND_DROP : KIND_ACCEPT;
      tag_out  <= post_tag;
      due_time <= DUE_W'(post_due);
      last     <= 1'b1;
    end else if (drain_fire) begin
      kind     <= KIND_DELIVER;
      tag_out  <= cell_tag[0];
      due_time <= DUE_W'(cell_due[0]);
      last     <= !more_ok;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("timed_event_queue: entry count beyond depth");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && (count != $past(count))) |->
      ((count == $past(count) + 1'b1) || (count == $past(count) - 1'b1)))
    else $error("timed_event_queue: entry count jumped");

  a_tick_time: assert property (@(posedge clk) disable iff (rst)
    (in_accept && (op == OP_TICK)) |=>
      ((now_time == $past(now_time) + 1'b1) || (now_time == TIME_MAX)))
    else $error("timed_event_queue: time counter not advanced by tick");

  a_drain_limit: assert property (@(posedge clk) disable iff (rst)
    (state == S_DRAIN) |-> (n_cnt < RES_W'(MAX_RESULTS)))
    else $error("timed_event_queue: too many deliveries for one tick");

endmodule
